// ===== src/oahsp_pkg.sv =====
`timescale 1ns / 1ps

package oahsp_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int SIZE_W    = 5;

    // Default store depth
    localparam int MAX_SLOTS_DEF = 16;

    // Size register after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd7;

    // Remainder unit: key bits folded in per cycle, key padded to a multiple
    localparam int MOD_DIGIT = 4;
    localparam int KEY_PAD_W = ((KEY_W + MOD_DIGIT - 1) / MOD_DIGIT) * MOD_DIGIT;
    localparam int MOD_STEPS = KEY_PAD_W / MOD_DIGIT;
    localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic start;       // load a new request
        logic mod_step;    // fold one digit of the key into the remainder
        logic chk;         // slot data valid, read next probe address
        logic finish;      // take the result, update the store
        logic out_load;    // move the result into the output register
        logic clear_step;  // clear one occupancy entry after reset
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mod_last;
        logic op_bad;
        logic stop;
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

// ===== src/open_address_hash_set_probe.sv =====
`timescale 1ns / 1ps
// Hash set of 31-bit keys, open addressing with triangular probing.
// Input channel s_*: one request (s_op: search, insert or remove; s_key).
// Output channel m_*: exactly one result per request (m_status, m_slot),
// in request order. Configuration channel cfg_*: writes the number of
// slots in use (cfg_table_size); cfg_ready is always high. The user must
// see that it is written only while no request is outstanding; the block
// does not enforce this. Steps: key mod size in the remainder unit (4 key
// bits per cycle), a read-issue state, the probe walk through the slot
// stores (up to as many probes as the active size) and the load into the
// output register; an unused op skips the walk. The probe walk through
// the registered slot-store read is the part whose length varies. One
// request is worked on at a time; s_ready returns once the result sits in
// the output register.
// Reset: the size returns to 7 and a clearing pass over all MAX_SLOTS
// entries empties the occupancy store; s_ready stays low until it completes.
// Stall: a result held by a low m_ready stays in the output register; the
// following request is processed but waits for the register to free up.
module open_address_hash_set_probe #(
    parameter int MAX_SLOTS = oahsp_pkg::MAX_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [oahsp_pkg::SIZE_W-1:0]     cfg_table_size,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [oahsp_pkg::OP_W-1:0]       s_op,
    input  logic [oahsp_pkg::KEY_W-1:0]      s_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [oahsp_pkg::STATUS_W-1:0]   m_status,
    output logic [oahsp_pkg::SLOT_W-1:0]     m_slot
);

    import oahsp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    oahsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Remainder unit, probe registers, slot stores and output register
    oahsp_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_table_size (cfg_table_size),
        .s_op           (s_op),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot)
    );

endmodule

// ===== src/oahsp_ram.sv =====
`timescale 1ns / 1ps

module oahsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/oahsp_ctrl.sv =====
`timescale 1ns / 1ps

module oahsp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  oahsp_pkg::sts_t   sts,
    output oahsp_pkg::cmd_t   cmd
);

    import oahsp_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    if (sts.op_bad) begin
                        cmd.finish = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.chk = 1'b1;
                if (sts.stop) begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Probing keeps going until a stop condition
    a_probe_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK && !sts.stop) |=> (state_reg == S_CHK))
        else $error("probe walk left early");

    // Every finished request waits for the output register
    a_finish_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (state_reg == S_DONE))
        else $error("finished request skipped hand-off");

    // No request is taken while the occupancy store is being cleared
    a_no_start_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == S_CLEAR && !sts.clear_last) |-> !s_ready)
        else $error("request accepted during clearing pass");

endmodule

// ===== src/oahsp_dp.sv =====
`timescale 1ns / 1ps

module oahsp_dp #(
    parameter int MAX_SLOTS = oahsp_pkg::MAX_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  oahsp_pkg::cmd_t                  cmd,
    output oahsp_pkg::sts_t                  sts,
    input  logic                             cfg_valid,
    input  logic [oahsp_pkg::SIZE_W-1:0]     cfg_table_size,
    input  logic [oahsp_pkg::OP_W-1:0]       s_op,
    input  logic [oahsp_pkg::KEY_W-1:0]      s_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [oahsp_pkg::STATUS_W-1:0]   m_status,
    output logic [oahsp_pkg::SLOT_W-1:0]     m_slot
);

    import oahsp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SLOTS);
    localparam int N_W    = SIZE_W;

    logic [SIZE_W-1:0]    size_reg;
    logic [N_W-1:0]       n_act;
    logic [N_W-1:0]       n_reg;
    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_PAD_W-1:0] kshift_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [N_W-1:0]       rem_reg;
    logic [N_W-1:0]       rem_next;
    logic [N_W-1:0]       h_reg;
    logic [N_W-1:0]       i_reg;
    logic [N_W:0]         i_plus;
    logic [N_W:0]         h_sum;
    logic [N_W-1:0]       h_adv;
    logic                 last_probe;
    logic [ADDR_W-1:0]    clr_reg;
    logic                 used_rd;
    logic [KEY_W-1:0]     key_rd;
    logic                 match;
    logic                 empty;
    logic [STATUS_W-1:0]  res_status;
    logic [N_W-1:0]       res_slot;
    logic                 used_wr;
    logic                 used_val;
    logic                 key_wr;
    logic [STATUS_W-1:0]  hold_status_reg;
    logic [SLOT_W-1:0]    hold_slot_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic                 used_we;
    logic [ADDR_W-1:0]    used_waddr;
    logic [ADDR_W-1:0]    h_addr;
    logic [ADDR_W-1:0]    rd_addr;

    // Size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            size_reg <= cfg_table_size;
        end
    end

    // Slots in use: zero acts as one, capped at the store depth
    always_comb begin
        if (size_reg == '0) begin
            n_act = N_W'(1);
        end else if (32'(size_reg) > 32'(MAX_SLOTS)) begin
            n_act = N_W'(MAX_SLOTS);
        end else begin
            n_act = size_reg;
        end
    end

    // Remainder of the key by the size, one key digit per cycle
    always_comb begin
        logic [N_W:0] t;
        logic [N_W-1:0] r;
        r = rem_reg;
        for (int j = 0; j < MOD_DIGIT; j++) begin
            t = {r, kshift_reg[KEY_PAD_W-1-j]};
            if (t >= {1'b0, n_reg}) begin
                t = t - {1'b0, n_reg};
            end
            r = t[N_W-1:0];
        end
        rem_next = r;
    end

    // Next probe slot: (h + i + 1) mod n, both terms below n
    assign i_plus     = {1'b0, i_reg} + (N_W+1)'(1);
    assign last_probe = (i_plus == {1'b0, n_reg});
    assign h_sum      = {1'b0, h_reg} + i_plus;
    assign h_adv      = (h_sum >= {1'b0, n_reg}) ? N_W'(h_sum - {1'b0, n_reg})
                                                 : h_sum[N_W-1:0];

    // Request, remainder and probe registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg      <= s_op;
            key_reg     <= s_key;
            kshift_reg  <= KEY_PAD_W'(s_key);
            n_reg       <= n_act;
            mod_cnt_reg <= '0;
            rem_reg     <= '0;
        end else if (cmd.mod_step) begin
            kshift_reg  <= kshift_reg << MOD_DIGIT;
            mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
            rem_reg     <= rem_next;
            if (sts.mod_last) begin
                h_reg <= rem_next;
                i_reg <= '0;
            end
        end else if (cmd.chk && !sts.stop) begin
            h_reg <= h_adv;
            i_reg <= i_plus[N_W-1:0];
        end
    end

    // Clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    // Probe outcome
    assign match = used_rd && (key_rd == key_reg);
    assign empty = !used_rd;

    // Result and store update
    always_comb begin
        res_status = ST_MISS;
        res_slot   = '0;
        used_wr    = 1'b0;
        used_val   = 1'b0;
        key_wr     = 1'b0;
        if (op_reg == OP_UNUSED) begin
            res_status = ST_MISS;
        end else if (match) begin
            res_status = ST_OK;
            res_slot   = h_reg;
            if (op_reg == OP_REMOVE) begin
                used_wr = 1'b1;
            end
        end else if (empty) begin
            if (op_reg == OP_INSERT) begin
                res_status = ST_OK;
                res_slot   = h_reg;
                used_wr    = 1'b1;
                used_val   = 1'b1;
                key_wr     = 1'b1;
            end
        end else if (op_reg == OP_INSERT) begin
            res_status = ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            hold_status_reg <= res_status;
            hold_slot_reg   <= SLOT_W'(res_slot);
        end
    end

    // Slot stores
    assign h_addr     = ADDR_W'(h_reg);
    assign rd_addr    = cmd.chk ? ADDR_W'(h_adv) : h_addr;
    assign used_we    = cmd.clear_step || (cmd.finish && used_wr);
    assign used_waddr = cmd.clear_step ? clr_reg : h_addr;

    oahsp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_used_ram (
        .aclk  (aclk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (cmd.clear_step ? 1'b0 : used_val),
        .raddr (rd_addr),
        .rdata (used_rd)
    );

    oahsp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_SLOTS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.finish && key_wr),
        .waddr (h_addr),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= hold_status_reg;
            m_slot_reg   <= hold_slot_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

    // Status to controller
    assign sts.mod_last   = (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
    assign sts.op_bad     = (op_reg == OP_UNUSED);
    assign sts.stop       = empty || match || last_probe;
    assign sts.clear_last = (clr_reg == ADDR_W'(MAX_SLOTS - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Probe position stays inside the active slots
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.chk |-> (h_reg < n_reg) && (i_reg < n_reg))
        else $error("probe outside active slots");

    // Keys are only ever written by an insert that found an empty slot
    a_key_write_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && key_wr) |-> (op_reg == OP_INSERT) && empty && cmd.chk)
        else $error("key store written outside insert");

    // A result appears only through a load command
    a_out_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("result appeared without load");

    // Loading never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule

// ===== verif/tb_open_address_hash_set_probe.sv =====
`timescale 1ns / 1ps

module tb_open_address_hash_set_probe;

    import oahsp_pkg::*;

    localparam int MAX_SLOTS    = MAX_SLOTS_DEF;
    localparam int ADDR_W       = $clog2(MAX_SLOTS);
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } probe_result_t;

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_table_size = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op           = OP_SEARCH;
    logic [KEY_W-1:0]    s_key          = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_slot;

    // Shadow of the hash set, updated at request accept time
    logic [SIZE_W-1:0]   shadow_size = SIZE_RESET;
    logic [KEY_W-1:0]    shadow_keys [MAX_SLOTS];
    bit                  shadow_used [MAX_SLOTS];

    probe_result_t       expected_results [$];
    int                  mismatches   = 0;
    int                  cycle_count  = 0;
    bit                  steady       = 1'b0;
    bit                  hold_pending = 1'b0;

    open_address_hash_set_probe #(
        .MAX_SLOTS (MAX_SLOTS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_table_size (cfg_table_size),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Apply one request to the shadow set and return the result it gives
    function automatic probe_result_t apply_request(input logic [OP_W-1:0] op,
                                                    input logic [KEY_W-1:0] key);
        int unsigned   n;
        int unsigned   h;
        int unsigned   where;
        bit            found;
        bit            empty;
        probe_result_t res;
        n     = (shadow_size == '0) ? 1 :
                ((32'(shadow_size) > MAX_SLOTS) ? MAX_SLOTS : 32'(shadow_size));
        h     = 32'(key) % n;
        where = 0;
        found = 1'b0;
        empty = 1'b0;
        res.status = ST_MISS;
        res.slot   = '0;
        // triangular probe walk, stops on an empty slot or the key
        if (op != OP_UNUSED) begin
            for (int unsigned i = 0; i < n && !found; i++) begin
                if (i != 0)
                    h = (h + i) % n;
                if (!shadow_used[h[ADDR_W-1:0]]) begin
                    found = 1'b1;
                    empty = 1'b1;
                    where = h;
                end else if (shadow_keys[h[ADDR_W-1:0]] == key) begin
                    found = 1'b1;
                    where = h;
                end
            end
        end
        case (op)
            OP_SEARCH, OP_REMOVE: begin
                if (found && !empty) begin
                    res.status = ST_OK;
                    res.slot   = where[SLOT_W-1:0];
                    if (op == OP_REMOVE)
                        shadow_used[where[ADDR_W-1:0]] = 1'b0;
                end
            end
            OP_INSERT: begin
                if (found) begin
                    if (empty) begin
                        shadow_keys[where[ADDR_W-1:0]] = key;
                        shadow_used[where[ADDR_W-1:0]] = 1'b1;
                    end
                    res.status = ST_OK;
                    res.slot   = where[SLOT_W-1:0];
                end else begin
                    res.status = ST_FULL;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        while (!steady && $urandom_range(99) < 35) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op    <= op;
        s_key   <= key;
        do
            @(posedge aclk);
        while (!s_ready);
        expected_results.push_back(apply_request(op, key));
    endtask

    // Drop valid and wait until every result is back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Size change, only with nothing in flight
    task automatic set_table_size(input logic [SIZE_W-1:0] size);
        wait_for_results();
        @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_table_size <= size;
        do
            @(posedge aclk);
        while (!cfg_ready);
        shadow_size = size;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result sink: random stalls, or a long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        probe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: m_status %0d m_slot %0d", m_status, m_slot);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, got %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_slot !== want.slot) begin
                    $error("m_slot: expected %0d, got %0d", want.slot, m_slot);
                    mismatches++;
                end
            end
        end
    end

    // Reset size of 7: collisions, stop on empty, no tombstone on remove
    task automatic test_basic_ops();
        send_request(OP_SEARCH, 31'd0);
        send_request(OP_INSERT, 31'd0);
        send_request(OP_INSERT, 31'd7);
        send_request(OP_INSERT, 31'd14);
        send_request(OP_INSERT, 31'd7);
        send_request(OP_SEARCH, 31'd14);
        send_request(OP_REMOVE, 31'd21);
        send_request(OP_UNUSED, 31'd7);
        send_request(OP_REMOVE, 31'd7);
        // gap left by the removal hides 14
        send_request(OP_SEARCH, 31'd14);
        send_request(OP_INSERT, 31'h7FFF_FFFF);
        send_request(OP_SEARCH, 31'h7FFF_FFFF);
    endtask

    // One slot: full table and zero size treated as one
    task automatic test_small_tables();
        set_table_size(5'd1);
        send_request(OP_INSERT, 31'd5);
        send_request(OP_SEARCH, 31'd5);
        set_table_size(5'd0);
        send_request(OP_INSERT, 31'd0);
        send_request(OP_REMOVE, 31'd0);
        send_request(OP_INSERT, 31'd5);
    endtask

    // Size above the store depth is clipped
    task automatic test_oversize_table();
        set_table_size(5'd31);
        send_request(OP_INSERT, 31'h7FFF_FFFF);
        send_request(OP_INSERT, 31'h2AAA_AAAA);
        send_request(OP_INSERT, 31'h5555_5555);
        send_request(OP_SEARCH, 31'h5555_5555);
        set_table_size(5'd17);
        send_request(OP_SEARCH, 31'h7FFF_FFFF);
    endtask

    // Random traffic over a small key pool so that keys collide and repeat
    task automatic test_random_traffic(input logic [SIZE_W-1:0] size, input int count,
                                       input bit calm);
        logic [KEY_W-1:0] pool [32];
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               mode;
        int               roll;
        set_table_size(size);
        steady = calm;
        mode   = 0;
        foreach (pool[k]) begin
            case ($urandom_range(2))
                0:       pool[k] = KEY_W'($urandom_range(63));
                1:       pool[k] = KEY_W'($urandom_range(1, 4000) * 16 + $urandom_range(3));
                default: pool[k] = KEY_W'($urandom());
            endcase
        end
        for (int n = 0; n < count; n++) begin
            // fill, mixed or drain runs of 25
            if (n % 25 == 0)
                mode = $urandom_range(2);
            roll = $urandom_range(99);
            case (mode)
                0:       op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_SEARCH :
                              (roll < 97) ? OP_REMOVE : OP_UNUSED;
                1:       op = (roll < 40) ? OP_INSERT : (roll < 75) ? OP_SEARCH :
                              (roll < 95) ? OP_REMOVE : OP_UNUSED;
                default: op = (roll < 15) ? OP_INSERT : (roll < 50) ? OP_SEARCH :
                              (roll < 97) ? OP_REMOVE : OP_UNUSED;
            endcase
            key = ($urandom_range(99) < 80) ? pool[5'($urandom_range(31))]
                                            : KEY_W'($urandom());
            send_request(op, key);
        end
        steady = 1'b0;
    endtask

    // Long sink hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        set_table_size(5'd16);
        hold_pending = 1'b1;
        for (int n = 0; n < 30; n++)
            send_request((n % 3 == 2) ? OP_SEARCH : OP_INSERT, KEY_W'($urandom()));
        wait_for_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_small_tables();
        test_oversize_table();
        test_random_traffic(5'd16, 150, 1'b1);
        test_random_traffic(5'd4,  150, 1'b0);
        test_random_traffic(5'd1,  100, 1'b0);
        test_random_traffic(5'd0,   60, 1'b0);
        test_backpressure();
        test_random_traffic(5'd31, 150, 1'b0);
        test_random_traffic(5'd13, 150, 1'b0);
        test_random_traffic(5'd3,  120, 1'b0);
        test_random_traffic(5'd8,  120, 1'b0);
        test_random_traffic(5'd16, 120, 1'b0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/oahsp_pkg.sv
src/oahsp_ram.sv
src/oahsp_ctrl.sv
src/oahsp_dp.sv
src/open_address_hash_set_probe.sv
verif/tb_open_address_hash_set_probe.sv
